FILE: design/textured_wall_column_pixel_unit_defines.svh
// assertion macros used by the checker
`ifndef TEXTURED_WALL_COLUMN_PIXEL_UNIT_DEFINES_SVH
`define TEXTURED_WALL_COLUMN_PIXEL_UNIT_DEFINES_SVH

// checked only while out of reset
`define TWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define TWC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/twc_pkg.sv
package twc_pkg;

  localparam int unsigned SCREEN_W_DEF    = 640;
  localparam int unsigned SCREEN_H_DEF    = 480;
  localparam int unsigned TEX_SIZE_DEF    = 64;
  localparam int unsigned ANIM_FRAMES_DEF = 10;

  localparam int unsigned STATIC_SLOTS = 5;
  localparam int unsigned H_SCALE_NUM  = 9;
  localparam int unsigned H_SCALE_DEN  = 10;
  localparam int unsigned FRAC_BITS    = 16;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned DIST_W  = 24;
  localparam int unsigned HIT_W   = 16;
  localparam int unsigned PIX_W   = 19;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned ROW_W   = 9;
  localparam int unsigned LOOK_W  = 10;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned TIDX_W  = 12;
  localparam int unsigned FRAME_W = 4;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned CH_N    = 3;

  localparam logic [COLOR_W-1:0] BACKGROUND   = 24'h050505;
  localparam logic [DIST_W-1:0]  BRIGHT_RESET = 24'h010000;

  localparam logic              REQ_LOAD         = 1'b0;
  localparam logic [KIND_W-1:0] KIND_NONE        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STATIC_LAST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_ANIM        = 3'd6;

endpackage

FILE: design/twc_ram.sv
module twc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/twc_div.sv
module twc_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 24,
  parameter int unsigned Q_W   = 8,
  parameter int unsigned TAG_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]            den_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        valid_o,
  output logic [LANES-1:0][Q_W-1:0]   quot_o,
  output logic [TAG_W-1:0]            tag_o
);

  // restoring division, one quotient bit per stage
  // acc holds {remainder, numerator bits left / quotient bits so far}
  localparam int unsigned ACC_W = DEN_W + Q_W;

  logic [Q_W-1:0]                  vld_q;
  logic [DEN_W-1:0]                den_q [Q_W];
  logic [TAG_W-1:0]                tag_q [Q_W];
  logic [LANES-1:0][ACC_W-1:0]     acc_q [Q_W];
  logic [LANES-1:0][ACC_W-1:0]     acc_d [Q_W];

  always_comb begin
    logic [LANES-1:0][ACC_W-1:0] src;
    logic [DEN_W-1:0]            den;
    logic [DEN_W:0]              t;
    logic [DEN_W:0]              diff;
    logic                        ge;
    for (int s = 0; s < Q_W; s++) begin
      if (s == 0) begin
        for (int l = 0; l < LANES; l++) begin
          src[l] = ACC_W'(num_i[l]);
        end
        den = den_i;
      end else begin
        src = acc_q[(s == 0) ? 0 : s - 1];
        den = den_q[(s == 0) ? 0 : s - 1];
      end
      for (int l = 0; l < LANES; l++) begin
        t    = src[l][ACC_W-1:Q_W-1];
        diff = t - {1'b0, den};
        ge   = (t >= {1'b0, den});
        acc_d[s][l] = {(ge ? diff[DEN_W-1:0] : t[DEN_W-1:0]), src[l][Q_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Q_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Q_W; s++) begin
        acc_q[s] <= acc_d[s];
        if (s == 0) begin
          den_q[s] <= den_i;
          tag_q[s] <= tag_i;
        end else begin
          den_q[s] <= den_q[(s == 0) ? 0 : s - 1];
          tag_q[s] <= tag_q[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot_o[l] = acc_q[Q_W-1][l][Q_W-1:0];
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign tag_o   = tag_q[Q_W-1];

endmodule

FILE: design/textured_wall_column_pixel_unit.sv
// channel  direction  handshake                  payload
// req      in         req_valid_i / req_ready_o  req_type .. anim_frame
// cfg      in         cfg_valid_i / cfg_ready_o  brightness_i
// res      out        res_valid_o / res_ready_i  pixel_index, color, is_wall
//
// one request per cycle unless the result port stalls; a pixel passes the front register,
// the bit-per-stage dividers for wall height, texture row and shading, with the span,
// memory, texel and product registers and the texture memory read between them
// reset clears the stage valid bits and sets brightness; the texture store is not cleared
// a stall at the result port freezes the whole pipeline in place, loads and pixels alike
module textured_wall_column_pixel_unit
  import twc_pkg::*;
#(
  parameter int unsigned SCREEN_W    = SCREEN_W_DEF,
  parameter int unsigned SCREEN_H    = SCREEN_H_DEF,
  parameter int unsigned TEX_SIZE    = TEX_SIZE_DEF,
  parameter int unsigned ANIM_FRAMES = ANIM_FRAMES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  logic                      req_type_i,
  input  logic [SLOT_W-1:0]         tex_slot_i,
  input  logic [TIDX_W-1:0]         texel_index_i,
  input  logic [COLOR_W-1:0]        texel_color_i,
  input  logic [COL_W-1:0]          column_x_i,
  input  logic [ROW_W-1:0]          row_i,
  input  logic [DIST_W-1:0]         distance_i,
  input  logic [HIT_W-1:0]          hit_u_i,
  input  logic [KIND_W-1:0]         wall_kind_i,
  input  logic signed [LOOK_W-1:0]  look_offset_i,
  input  logic [FRAME_W-1:0]        anim_frame_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [DIST_W-1:0]         brightness_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic [PIX_W-1:0]          pixel_index_o,
  output logic [COLOR_W-1:0]        color_o,
  output logic                      is_wall_o
);

  localparam longint unsigned H_NUM =
      longint'(SCREEN_W) * longint'(H_SCALE_NUM) * (64'd1 << FRAC_BITS);
  localparam int unsigned HQ_W  = $clog2(H_NUM + 1);
  localparam int unsigned HD_W  = DIST_W + $clog2(H_SCALE_DEN);
  localparam int unsigned TQ_W  = $clog2(TEX_SIZE);
  localparam int unsigned SP_W  = HQ_W + 2;
  localparam int unsigned AREA  = TEX_SIZE * TEX_SIZE;
  localparam int unsigned SLOTS = STATIC_SLOTS + ANIM_FRAMES;
  localparam int unsigned DEPTH = SLOTS * AREA;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SL_W  = $clog2(SLOTS);
  localparam int unsigned VN_W  = HQ_W + TQ_W;
  localparam int unsigned PR_W  = CH_W + DIST_W;
  localparam logic [HQ_W:0] H_NUM_V = (HQ_W + 1)'(H_NUM);

  typedef struct packed {
    logic               is_load;
    logic               ld_ok;
    logic [AW-1:0]      ld_addr;
    logic [COLOR_W-1:0] ld_data;
    logic               emit;
    logic [PIX_W-1:0]   pix;
    logic [DIST_W-1:0]  distance;
    logic [ROW_W-1:0]   row;
    logic [LOOK_W-1:0]  look;
    logic [TQ_W-1:0]    u;
    logic [SL_W-1:0]    slot;
    logic               black;
  } front_t;

  typedef struct packed {
    logic               is_load;
    logic               ld_ok;
    logic [AW-1:0]      ld_addr;
    logic [COLOR_W-1:0] ld_data;
    logic               emit;
    logic [PIX_W-1:0]   pix;
    logic [DIST_W-1:0]  distance;
    logic               wall;
    logic [TQ_W-1:0]    u;
    logic [SL_W-1:0]    slot;
    logic               black;
  } back_t;

  typedef struct packed {
    logic               we;
    logic [AW-1:0]      addr;
    logic [COLOR_W-1:0] wdata;
    logic               emit;
    logic [PIX_W-1:0]   pix;
    logic [DIST_W-1:0]  distance;
    logic               wall;
    logic               black;
  } mem_t;

  typedef struct packed {
    logic               emit;
    logic [PIX_W-1:0]   pix;
    logic [DIST_W-1:0]  distance;
    logic               wall;
    logic               black;
  } texs_t;

  typedef struct packed {
    logic               emit;
    logic [PIX_W-1:0]   pix;
    logic               wall;
    logic               pass;
    logic [COLOR_W-1:0] texel;
  } shd_t;

  logic en;
  logic [DIST_W-1:0] brightness_q;

  // front stage
  logic [SL_W-1:0] frame_slot [2**FRAME_W];
  front_t a_d, a_q;
  logic [HD_W-1:0] a_den_d, a_den_q;
  logic a_valid_q;

  // wall height
  logic h_valid;
  logic [0:0][HQ_W-1:0] h_quot;
  front_t h_tag;

  // span stage
  logic signed [SP_W-1:0] half_s, mid_s, look_s, start_s, end_s, y_s, k_s;
  back_t s_d, s_q;
  logic [0:0][VN_W-1:0] s_num_d, s_num_q;
  logic [HQ_W-1:0] s_den_q;
  logic s_valid_q;

  // texture row
  logic v_valid;
  logic [0:0][TQ_W-1:0] v_quot;
  back_t v_tag;

  // memory stage
  logic [AW-1:0] rd_addr;
  mem_t m_d, m_q;
  logic m_valid_q;
  logic [COLOR_W-1:0] ram_rdata;

  // texel stage
  texs_t t_q;
  logic t_valid_q;
  logic [COLOR_W-1:0] texel;

  // product stage
  shd_t p_d, p_q;
  logic [CH_N-1:0][PR_W-1:0] p_prod_d, p_prod_q;
  logic [DIST_W-1:0] p_den_q;
  logic p_valid_q;

  // shading
  logic d_valid;
  logic [CH_N-1:0][CH_W-1:0] d_quot;
  shd_t d_tag;

  logic res_valid_q;
  logic [PIX_W-1:0] pixel_index_q;
  logic [COLOR_W-1:0] color_q;
  logic is_wall_q;

  assign en          = !res_valid_q || res_ready_i;
  assign req_ready_o = en;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    for (int i = 0; i < 2**FRAME_W; i++) begin
      frame_slot[i] = SL_W'(STATIC_SLOTS + i % ANIM_FRAMES);
    end
  end

  always_comb begin
    a_d.is_load  = (req_type_i == REQ_LOAD);
    a_d.ld_ok    = (32'(tex_slot_i) < SLOTS) && (32'(texel_index_i) < AREA);
    a_d.ld_addr  = AW'(32'(tex_slot_i) * 32'(AREA) + 32'(texel_index_i));
    a_d.ld_data  = texel_color_i;
    a_d.emit     = !a_d.is_load && (32'(column_x_i) < SCREEN_W) && (32'(row_i) < SCREEN_H);
    a_d.pix      = PIX_W'(32'(SCREEN_W) * 32'(row_i) + 32'(column_x_i));
    a_d.distance = distance_i;
    a_d.row      = row_i;
    a_d.look     = look_offset_i;
    a_d.u        = TQ_W'((32'(hit_u_i) * 32'(TEX_SIZE)) >> FRAC_BITS);
    priority if (wall_kind_i != KIND_NONE && wall_kind_i <= KIND_STATIC_LAST) begin
      a_d.slot  = SL_W'(wall_kind_i - KIND_W'(1));
      a_d.black = 1'b0;
    end else if (wall_kind_i == KIND_ANIM) begin
      a_d.slot  = frame_slot[anim_frame_i];
      a_d.black = 1'b0;
    end else begin
      a_d.slot  = '0;
      a_d.black = 1'b1;
    end
    a_den_d = HD_W'(32'(distance_i) * 32'(H_SCALE_DEN));
  end

  twc_div #(
    .LANES(1), .NUM_W(HQ_W + 1), .DEN_W(HD_W), .Q_W(HQ_W), .TAG_W($bits(front_t))
  ) u_height_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid_q),
    .num_i   (H_NUM_V),
    .den_i   (a_den_q),
    .tag_i   (a_q),
    .valid_o (h_valid),
    .quot_o  (h_quot),
    .tag_o   (h_tag)
  );

  always_comb begin
    half_s  = $signed({3'b000, h_quot[0][HQ_W-1:1]});
    mid_s   = SP_W'(SCREEN_H / 2);
    look_s  = {{(SP_W - LOOK_W){h_tag.look[LOOK_W-1]}}, h_tag.look};
    y_s     = $signed({{(SP_W - ROW_W){1'b0}}, h_tag.row}) + SP_W'(1);
    start_s = mid_s - half_s + look_s;
    end_s   = mid_s + half_s + look_s;
    k_s     = y_s - start_s;

    s_d.is_load  = h_tag.is_load;
    s_d.ld_ok    = h_tag.ld_ok;
    s_d.ld_addr  = h_tag.ld_addr;
    s_d.ld_data  = h_tag.ld_data;
    s_d.emit     = h_tag.emit;
    s_d.pix      = h_tag.pix;
    s_d.distance = h_tag.distance;
    s_d.wall     = (h_tag.distance != '0) && (h_quot[0] != '0) && (y_s >= start_s) &&
                   (y_s < end_s);
    s_d.u        = h_tag.u;
    s_d.slot     = h_tag.slot;
    s_d.black    = h_tag.black;
    s_num_d[0]   = VN_W'(k_s[HQ_W-1:0]) * VN_W'(TEX_SIZE);
  end

  twc_div #(
    .LANES(1), .NUM_W(VN_W), .DEN_W(HQ_W), .Q_W(TQ_W), .TAG_W($bits(back_t))
  ) u_row_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid_q),
    .num_i   (s_num_q),
    .den_i   (s_den_q),
    .tag_i   (s_q),
    .valid_o (v_valid),
    .quot_o  (v_quot),
    .tag_o   (v_tag)
  );

  always_comb begin
    rd_addr = AW'(32'(v_tag.slot) * 32'(AREA) + 32'(v_quot[0]) * 32'(TEX_SIZE)
                  + 32'(v_tag.u));
    m_d.we       = v_tag.is_load && v_tag.ld_ok;
    m_d.addr     = v_tag.is_load ? v_tag.ld_addr : rd_addr;
    m_d.wdata    = v_tag.ld_data;
    m_d.emit     = v_tag.emit;
    m_d.pix      = v_tag.pix;
    m_d.distance = v_tag.distance;
    m_d.wall     = v_tag.wall;
    m_d.black    = v_tag.black;
  end

  twc_ram #(
    .WIDTH(COLOR_W), .DEPTH(DEPTH)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (en && m_valid_q && m_q.we),
    .waddr_i (m_q.addr),
    .wdata_i (m_q.wdata),
    .re_i    (en),
    .raddr_i (m_q.addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    texel = t_q.black ? '0 : ram_rdata;
    for (int c = 0; c < CH_N; c++) begin
      p_prod_d[c] = PR_W'(32'(texel[c*CH_W +: CH_W]) * 32'(brightness_q));
    end
    p_d.emit  = t_q.emit;
    p_d.pix   = t_q.pix;
    p_d.wall  = t_q.wall;
    p_d.pass  = (brightness_q >= t_q.distance);
    p_d.texel = texel;
  end

  twc_div #(
    .LANES(CH_N), .NUM_W(PR_W), .DEN_W(DIST_W), .Q_W(CH_W), .TAG_W($bits(shd_t))
  ) u_shade_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_valid_q),
    .num_i   (p_prod_q),
    .den_i   (p_den_q),
    .tag_i   (p_q),
    .valid_o (d_valid),
    .quot_o  (d_quot),
    .tag_o   (d_tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BRIGHT_RESET;
      a_valid_q    <= 1'b0;
      s_valid_q    <= 1'b0;
      m_valid_q    <= 1'b0;
      t_valid_q    <= 1'b0;
      p_valid_q    <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        brightness_q <= brightness_i;
      end
      if (en) begin
        a_valid_q   <= req_valid_i;
        s_valid_q   <= h_valid;
        m_valid_q   <= v_valid;
        t_valid_q   <= m_valid_q;
        p_valid_q   <= t_valid_q;
        res_valid_q <= d_valid && d_tag.emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q      <= a_d;
      a_den_q  <= a_den_d;
      s_q      <= s_d;
      s_num_q  <= s_num_d;
      s_den_q  <= h_quot[0];
      m_q      <= m_d;
      t_q.emit     <= m_q.emit;
      t_q.pix      <= m_q.pix;
      t_q.distance <= m_q.distance;
      t_q.wall     <= m_q.wall;
      t_q.black    <= m_q.black;
      p_q      <= p_d;
      p_prod_q <= p_prod_d;
      p_den_q  <= t_q.distance;
      pixel_index_q <= d_tag.pix;
      is_wall_q     <= d_tag.wall;
      if (!d_tag.wall) begin
        color_q <= BACKGROUND;
      end else if (d_tag.pass) begin
        color_q <= d_tag.texel;
      end else begin
        color_q <= d_quot;
      end
    end
  end

  assign res_valid_o   = res_valid_q;
  assign pixel_index_o = pixel_index_q;
  assign color_o       = color_q;
  assign is_wall_o     = is_wall_q;

endmodule

FILE: design/twc_checker.sv
`include "textured_wall_column_pixel_unit_defines.svh"

module twc_checker
  import twc_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     req_ready_o,
  input logic                     res_valid_o,
  input logic                     res_ready_i,
  input logic [PIX_W-1:0]         pixel_index_o,
  input logic [COLOR_W-1:0]       color_o,
  input logic                     is_wall_o
);

  `TWC_ASSERT(res_hold_a, res_valid_o && !res_ready_i |=> res_valid_o,
              "result dropped while stalled")

  `TWC_ASSERT(res_stable_a, res_valid_o && !res_ready_i |=>
              $stable(pixel_index_o) && $stable(color_o) && $stable(is_wall_o),
              "result changed while stalled")

  `TWC_ASSERT(bg_color_a, res_valid_o && !is_wall_o |-> color_o == BACKGROUND,
              "non-wall pixel not background")

  `TWC_ASSERT_ALWAYS(req_stall_a, req_ready_o == (!res_valid_o || res_ready_i),
                     "request ready does not follow result stall")

  `TWC_ASSERT_ALWAYS(reset_idle_a, !rst_ni |-> !res_valid_o, "result valid during reset")

endmodule

bind textured_wall_column_pixel_unit twc_checker u_twc_checker (.*);
